### rtl/fso_pkg.sv
`default_nettype none

package fso_pkg;

  // Configuration port geometry. The index has room for codes beyond the
  // two defined registers; writes to those codes are dropped.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FB_SCALE   = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] FREQ_SCALE_RST = 32'd733007752;
  localparam logic [CFG_DATA_W-1:0] FB_SCALE_RST   = 32'd85445659;

  // Constants for building the sine table at elaboration.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  // Taylor series divisors (2n)(2n+1) for the terms after x.
  localparam logic [63:0] TAYLOR_DIV [1:9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

endpackage

`default_nettype wire

### rtl/feedback_sine_oscillator.sv
`default_nettype none

// Sine oscillator with phase feedback. Each input word carries a frequency
// in hertz (signed Q20.12) and a feedback amount in radians (signed Q4.12)
// and yields one output word, a linearly interpolated sine sample in signed
// Q1.15. Before the table read, the 32-bit phase is offset by feedback times
// fb_scale times the previous sample, so the last output modulates the
// current phase; after the read the phase advances by frequency times
// freq_scale and wraps. The offset and increment products are truncated
// toward zero. A word passes the states ST_OFS, ST_INC, ST_INT and ST_OUT
// in turn. The accepting edge forms feedback times last sample. ST_OFS and
// ST_INC share one 32x32 multiplier between the offset and the phase
// increment, and the registered sine table read overlaps ST_INC. ST_INT
// forms the interpolation product, and ST_OUT loads the result once the
// output is free. Input reopens in the cycle after the result is registered,
// so no new word is taken while one is in flight. A finished result
// may wait on the output while the next word is already being worked on; that
// word then waits in the last stage, and input stays closed until the output
// frees. The sine table is a memory of TABLE_SIZE + 1 entries, including one
// guard entry, filled once at start-up and read at two neighboring addresses
// per access. Configuration writes (freq_scale at index 0, fb_scale at
// index 1) take effect at once and are meant to happen only while the block
// is idle.

module feedback_sine_oscillator #(
  parameter int TABLE_SIZE  = 8192,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           cfg_we,
  input  wire logic [fso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fso_pkg::CFG_DATA_W-1:0] cfg_wdata,

  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [31:0]             in_frequency,
  input  wire logic signed [15:0]             in_feedback,

  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [15:0]                  out_sample
);

  import fso_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int AW    = IDX_W + 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int DPW   = SB + 18;
  localparam int VW    = SB + 10;
  localparam int SHL   = (SB < 16) ? 16 - SB : 0;
  localparam int SHR   = (SB > 16) ? SB - 16 : 0;

  localparam logic signed [VW-1:0] SAT_HI = VW'(32767);
  localparam logic signed [VW-1:0] SAT_LO = VW'(-32768);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OFS  = 3'd1;
  localparam logic [2:0] ST_INC  = 3'd2;
  localparam logic [2:0] ST_INT  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // One quarter-wave point from a Q30 Taylor series, rounded half up.
  function automatic logic signed [SB-1:0] quarter_sine(input logic [31:0] k);
    logic [63:0]        theta;
    logic [63:0]        theta2;
    logic [63:0]        term;
    logic [63:0]        amp;
    logic [63:0]        v;
    logic signed [63:0] sum;
    theta  = (64'(k) * TWO_PI_Q30) / 64'(TABLE_SIZE);
    theta2 = (theta * theta) >> 30;
    term   = theta;
    sum    = $signed(theta);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * theta2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    amp = (64'd1 << (SB - 1)) - 64'd1;
    v   = ($unsigned(sum) * amp + (ONE_Q30 >> 1)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return SB'(v);
  endfunction

  // Full table from the quarter wave, mirrored; the last entry repeats entry 0.
  logic signed [SB-1:0] sine_rom [0:TABLE_SIZE];

  initial begin
    logic [31:0] j;
    logic [31:0] n;
    n = 32'(TABLE_SIZE);
    for (int i = 0; i <= TABLE_SIZE; i++) begin
      j = 32'(i) & (n - 32'd1);
      if (j <= n / 4) begin
        sine_rom[i] = quarter_sine(j);
      end else if (j <= n / 2) begin
        sine_rom[i] = quarter_sine(n / 2 - j);
      end else if (j <= 3 * n / 4) begin
        sine_rom[i] = -quarter_sine(j - n / 2);
      end else begin
        sine_rom[i] = -quarter_sine(n - j);
      end
    end
  end

  logic [2:0]          state_r, state_nxt;
  logic [31:0]         freq_scale_r;
  logic [31:0]         fb_scale_r;
  logic [31:0]         phase_r;
  logic signed [15:0]  last_sample_r;
  logic signed [31:0]  freq_r;
  logic signed [31:0]  fbl_r;
  logic [31:0]         ofs_mag_r;
  logic [31:0]         inc_mag_r;
  logic [15:0]         frac_r;
  logic signed [SB-1:0] rd0_r;
  logic signed [SB-1:0] rd1_r;
  logic signed [DPW-1:0] dprod_r;
  logic                out_valid_r;
  logic signed [15:0]  out_sample_r;

  logic                in_take;
  logic                out_free;
  logic [31:0]         fbl_mag;
  logic [31:0]         freq_mag;
  logic [31:0]         mul_a;
  logic [63:0]         mul_p;
  logic [31:0]         rd_phase;
  logic [IDX_W-1:0]    rd_idx;
  logic [AW-1:0]       addr0;
  logic [AW-1:0]       addr1;
  logic signed [SB:0]  diff;
  logic signed [16:0]  frac_s;
  logic signed [DPW-1:0] dsh;
  logic signed [VW-1:0] val;
  logic signed [VW-1:0] conv;
  logic signed [15:0]  sample_sat;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_take    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_free   = !out_valid_r || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_scale_r <= FREQ_SCALE_RST;
      fb_scale_r   <= FB_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ_SCALE: freq_scale_r <= cfg_wdata;
        REG_FB_SCALE:   fb_scale_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Magnitudes for the truncating products; the sign is applied afterwards
  // as an add or a subtract against the phase.
  assign fbl_mag  = fbl_r[31]  ? 32'(-fbl_r)  : fbl_r;
  assign freq_mag = freq_r[31] ? 32'(-freq_r) : freq_r;

  // One 32x32 multiplier serves the feedback offset and then the increment.
  assign mul_a = (state_r == ST_OFS) ? fbl_mag : freq_mag;
  assign mul_p = 64'(mul_a) * 64'((state_r == ST_OFS) ? fb_scale_r : freq_scale_r);

  // Read phase and the two neighboring table addresses.
  assign rd_phase = fbl_r[31] ? (phase_r - ofs_mag_r) : (phase_r + ofs_mag_r);
  assign rd_idx   = rd_phase[16 +: IDX_W];
  assign addr0    = {1'b0, rd_idx};
  assign addr1    = {1'b0, rd_idx} + AW'(1);

  // Interpolation and conversion to Q1.15.
  assign diff   = (SB+1)'(rd1_r) - (SB+1)'(rd0_r);
  assign frac_s = $signed({1'b0, frac_r});
  assign dsh    = dprod_r >>> 16;
  assign val    = VW'(rd0_r) + VW'(dsh);
  assign conv   = (val <<< SHL) >>> SHR;

  always_comb begin
    if (conv > SAT_HI) begin
      sample_sat = 16'sh7fff;
    end else if (conv < SAT_LO) begin
      sample_sat = -16'sh8000;
    end else begin
      sample_sat = 16'(conv);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_OFS;
      ST_OFS:  state_nxt = ST_INC;
      ST_INC:  state_nxt = ST_INT;
      ST_INT:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sine table: two registered reads per access.
  always_ff @(posedge clk) begin
    if (state_r == ST_INC) begin
      rd0_r <= sine_rom[addr0];
      rd1_r <= sine_rom[addr1];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      freq_r <= in_frequency;
      fbl_r  <= 32'(in_feedback) * 32'(last_sample_r);
    end
    if (state_r == ST_OFS) begin
      ofs_mag_r <= mul_p[58:27];
    end
    if (state_r == ST_INC) begin
      inc_mag_r <= mul_p[59:28];
      frac_r    <= rd_phase[15:0];
    end
    if (state_r == ST_INT) begin
      dprod_r <= DPW'(diff) * DPW'(frac_s);
    end
    if (state_r == ST_OUT && out_free) begin
      out_sample_r <= sample_sat;
    end
  end

  // Control and oscillator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= '0;
      last_sample_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INT) begin
        phase_r <= freq_r[31] ? (phase_r - inc_mag_r) : (phase_r + inc_mag_r);
      end
      if (state_r == ST_OUT && out_free) begin
        last_sample_r <= sample_sat;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/fso_checker.sv
`default_nettype none

module fso_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           cfg_we,
  input wire logic [fso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [fso_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic signed [31:0]             in_frequency,
  input wire logic signed [15:0]             in_feedback,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [15:0]             out_sample
);

  import fso_pkg::*;

  // Only one word is in flight, so input is closed right after a word enters.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // Checks that out_valid is high after an accepted word.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##5 out_valid)
    else $error("no result five cycles after an accepted word");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("stalled output word changed or dropped");

  // A waiting input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_frequency) && $stable(in_feedback)))
    else $error("waiting input word changed or withdrawn");

  // Configuration is written only while the block is idle and empty.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> (in_ready && !in_valid && !out_valid
                && !$isunknown({cfg_index, cfg_wdata})))
    else $error("configuration write while a word is in flight");

endmodule

bind feedback_sine_oscillator fso_checker u_fso_checker (.*);

`default_nettype wire
